### design/bpe_pkg.sv
`timescale 1ns / 1ps

package bpe_pkg;

   localparam int MAX_POINTS_DEF = 64;

   localparam int OP_W     = 2;
   localparam int IDX_W    = 6;
   localparam int POS_W    = 16;
   localparam int LVL_W    = 16;
   localparam int RATE_W   = 32;
   localparam int SAMPLE_W = 16;
   localparam int PC_W     = 7;
   localparam int TIME_W   = 32;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_STEP    = 2'd3;

   localparam logic [TIME_W-1:0] TIME_ONE   = 32'hFFFF_0000;
   localparam logic [LVL_W-1:0]  LEVEL_FULL = 16'hFFFF;

   typedef struct packed {
      logic             hold;
      logic [LVL_W-1:0] level;
      logic [POS_W-1:0] pos;
   } bp_entry_type;

endpackage

### design/breakpoint_envelope_generator.sv
// Load, restart and release are done at the transfer; busy stays low after them.
// Step, inactive envelope: result strobe in the cycle after the transfer.
// Step, active: each segment visited passes through memory read and walk check; a hold or
// end-of-table result follows directly, an interpolation adds multiply, radix-2 divider
// and finish, skipping the divider on a zero-length segment. One item in flight.
// Receiver cannot stall. Synchronous reset clears time, rate, segment, hold, point count.
`timescale 1ns / 1ps

module breakpoint_envelope_generator #(
   parameter int MAX_POINTS = bpe_pkg::MAX_POINTS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bpe_pkg::OP_W-1:0]      req_op,
   input  logic [bpe_pkg::IDX_W-1:0]     req_point_index,
   input  logic [bpe_pkg::POS_W-1:0]     req_point_pos,
   input  logic [bpe_pkg::LVL_W-1:0]     req_point_level,
   input  logic                          req_point_sustain,
   input  logic [bpe_pkg::RATE_W-1:0]    req_rate,
   input  logic [bpe_pkg::SAMPLE_W-1:0]  req_sample_count,
   output logic                          rsp_valid,
   output logic [bpe_pkg::LVL_W-1:0]     rsp_level,
   output logic [bpe_pkg::POS_W-1:0]     rsp_play_pos,
   output logic                          rsp_pos_valid,
   input  logic                          csr_wr_en,
   input  logic [bpe_pkg::PC_W-1:0]      csr_wr_data
);
   import bpe_pkg::*;

   localparam int SEG_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int CMP_W   = (CNT_W > PC_W) ? CNT_W : PC_W;
   localparam int PROD_W  = LVL_W + TIME_W;
   localparam int ADV_W   = SAMPLE_W + RATE_W;
   localparam int Q_W     = PROD_W - POS_W;
   localparam int DCNT_W  = $clog2(Q_W);
   localparam int SUM_W   = Q_W + 2;
   localparam int T_W     = ADV_W + 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_WALK = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [RATE_W-1:0]   rate_ff, rate_in;
   logic [SEG_W-1:0]    seg_ff, seg_in;
   logic                held_ff, held_in;
   logic [PC_W-1:0]     point_count_ff, point_count_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [LVL_W-1:0]    dl_mag_ff, dl_mag_in;
   logic [TIME_W-1:0]   dt_mag_ff, dt_mag_in;
   logic                neg_ff, neg_in;
   logic                zl_ff, zl_in;
   logic [LVL_W-1:0]    l0_ff, l0_in;
   logic [POS_W-1:0]    den_ff, den_in;
   logic [ADV_W-1:0]    adv_ff, adv_in;
   logic [Q_W-1:0]      quo_ff, quo_in;
   logic [POS_W-1:0]    rem_ff, rem_in;
   logic [DCNT_W-1:0]   dcnt_ff, dcnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LVL_W-1:0]    rsp_level_ff, rsp_level_in;
   logic [POS_W-1:0]    rsp_play_pos_ff, rsp_play_pos_in;
   logic                rsp_pos_valid_ff, rsp_pos_valid_in;

   bp_entry_type        bp_mem [MAX_POINTS];
   bp_entry_type        rd_a_ff, rd_b_ff;
   bp_entry_type        wr_entry;
   logic                mem_we;
   logic [SEG_W-1:0]    wr_addr;
   logic [SEG_W-1:0]    seg_nx;

   logic [CMP_W-1:0]    pc_ext, n_full;
   logic [CNT_W-1:0]    n_cnt, last_idx, seg_ext;
   logic                more;

   logic signed [LVL_W:0]  dl;
   logic signed [TIME_W:0] dt;
   logic [PROD_W-1:0]      prod;
   logic [POS_W:0]         rem_sh;
   logic                   qbit;
   logic [SUM_W-1:0]       sq, vsum;
   logic [LVL_W-1:0]       vsat;
   logic [T_W-1:0]         tsum;
   logic [TIME_W-1:0]      tnew;

   assign pc_ext   = CMP_W'(point_count_ff);
   assign n_full   = (pc_ext < CMP_W'(MAX_POINTS)) ? pc_ext : CMP_W'(MAX_POINTS);
   assign n_cnt    = CNT_W'(n_full);
   assign last_idx = n_cnt - 1'b1;
   assign seg_ext  = CNT_W'(seg_ff);
   assign more     = seg_ext < last_idx;
   assign seg_nx   = more ? seg_ff + 1'b1 : seg_ff;

   assign wr_addr  = SEG_W'(req_point_index);
   assign wr_entry = '{hold: req_point_sustain, level: req_point_level, pos: req_point_pos};

   assign dl = $signed({1'b0, rd_b_ff.level}) - $signed({1'b0, rd_a_ff.level});
   assign dt = $signed({1'b0, time_ff}) - $signed({1'b0, rd_a_ff.pos, 16'h0000});

   assign prod   = PROD_W'(dl_mag_ff) * PROD_W'(dt_mag_ff);
   assign rem_sh = {rem_ff, quo_ff[Q_W-1]};
   assign qbit   = rem_sh >= {1'b0, den_ff};

   assign sq   = neg_ff ? (SUM_W'(0) - SUM_W'(quo_ff)) : SUM_W'(quo_ff);
   assign vsum = SUM_W'(l0_ff) + sq;
   assign tsum = T_W'(time_ff) + T_W'(adv_ff);
   assign tnew = (tsum > T_W'(TIME_ONE)) ? TIME_ONE : tsum[TIME_W-1:0];

   always_comb begin
      priority if (vsum[SUM_W-1]) begin
         vsat = '0;
      end else if (vsum[SUM_W-2:LVL_W] != '0) begin
         vsat = LEVEL_FULL;
      end else begin
         vsat = vsum[LVL_W-1:0];
      end
   end

   always_comb begin
      state_in         = state_ff;
      time_in          = time_ff;
      rate_in          = rate_ff;
      seg_in           = seg_ff;
      held_in          = held_ff;
      point_count_in   = csr_wr_en ? csr_wr_data : point_count_ff;
      sample_in        = sample_ff;
      dl_mag_in        = dl_mag_ff;
      dt_mag_in        = dt_mag_ff;
      neg_in           = neg_ff;
      zl_in            = zl_ff;
      l0_in            = l0_ff;
      den_in           = den_ff;
      adv_in           = adv_ff;
      quo_in           = quo_ff;
      rem_in           = rem_ff;
      dcnt_in          = dcnt_ff;
      rsp_valid_in     = 1'b0;
      rsp_level_in     = rsp_level_ff;
      rsp_play_pos_in  = rsp_play_pos_ff;
      rsp_pos_valid_in = rsp_pos_valid_ff;
      mem_we           = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (req_op)
                  OP_LOAD: begin
                     mem_we = 32'(req_point_index) < MAX_POINTS;
                  end
                  OP_RESTART: begin
                     time_in = '0;
                     rate_in = req_rate;
                     seg_in  = '0;
                     held_in = 1'b1;
                  end
                  OP_RELEASE: begin
                     held_in = 1'b0;
                  end
                  OP_STEP: begin
                     sample_in = req_sample_count;
                     if (n_cnt < CNT_W'(2)) begin
                        rsp_valid_in     = 1'b1;
                        rsp_level_in     = LEVEL_FULL;
                        rsp_play_pos_in  = '0;
                        rsp_pos_valid_in = 1'b0;
                     end else begin
                        if (seg_ext > last_idx) begin
                           seg_in = SEG_W'(last_idx);
                        end
                        state_in = S_READ;
                     end
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            priority if (more && (time_ff > {rd_b_ff.pos, 16'h0000}) &&
                         !(rd_a_ff.hold && held_ff)) begin
               seg_in   = seg_ff + 1'b1;
               state_in = S_READ;
            end else if ((rd_a_ff.hold && held_ff) || !more) begin
               rsp_valid_in     = 1'b1;
               rsp_level_in     = rd_a_ff.level;
               rsp_play_pos_in  = time_ff[TIME_W-1:TIME_W-POS_W];
               rsp_pos_valid_in = 1'b1;
               state_in         = S_IDLE;
            end else begin
               dl_mag_in = dl[LVL_W] ? LVL_W'(-dl) : dl[LVL_W-1:0];
               dt_mag_in = dt[TIME_W] ? TIME_W'(-dt) : dt[TIME_W-1:0];
               neg_in    = dl[LVL_W] ^ dt[TIME_W] ^ (rd_b_ff.pos < rd_a_ff.pos);
               l0_in     = rd_a_ff.level;
               zl_in     = rd_b_ff.pos == rd_a_ff.pos;
               den_in    = (rd_b_ff.pos >= rd_a_ff.pos) ? rd_b_ff.pos - rd_a_ff.pos
                                                        : rd_a_ff.pos - rd_b_ff.pos;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            adv_in  = ADV_W'(sample_ff) * ADV_W'(rate_ff);
            rem_in  = '0;
            dcnt_in = '0;
            if (zl_ff) begin
               quo_in   = '0;
               state_in = S_FIN;
            end else begin
               quo_in   = prod[PROD_W-1:POS_W];
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in  = qbit ? POS_W'(rem_sh - {1'b0, den_ff}) : rem_sh[POS_W-1:0];
            quo_in  = {quo_ff[Q_W-2:0], qbit};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DCNT_W'(Q_W - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            time_in          = tnew;
            rsp_valid_in     = 1'b1;
            rsp_level_in     = vsat;
            rsp_play_pos_in  = tnew[TIME_W-1:TIME_W-POS_W];
            rsp_pos_valid_in = 1'b1;
            state_in         = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         time_ff        <= '0;
         rate_ff        <= '0;
         seg_ff         <= '0;
         held_ff        <= 1'b0;
         point_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         time_ff        <= time_in;
         rate_ff        <= rate_in;
         seg_ff         <= seg_in;
         held_ff        <= held_in;
         point_count_ff <= point_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff        <= sample_in;
      dl_mag_ff        <= dl_mag_in;
      dt_mag_ff        <= dt_mag_in;
      neg_ff           <= neg_in;
      zl_ff            <= zl_in;
      l0_ff            <= l0_in;
      den_ff           <= den_in;
      adv_ff           <= adv_in;
      quo_ff           <= quo_in;
      rem_ff           <= rem_in;
      dcnt_ff          <= dcnt_in;
      rsp_level_ff     <= rsp_level_in;
      rsp_play_pos_ff  <= rsp_play_pos_in;
      rsp_pos_valid_ff <= rsp_pos_valid_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bp_mem[wr_addr] <= wr_entry;
      end
      rd_a_ff <= bp_mem[seg_ff];
      rd_b_ff <= bp_mem[seg_nx];
   end

   assign busy          = state_ff != S_IDLE;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_level     = rsp_level_ff;
   assign rsp_play_pos  = rsp_play_pos_ff;
   assign rsp_pos_valid = rsp_pos_valid_ff;

endmodule
